### rtl/c128_pkg.sv
package c128_pkg;

   localparam logic [1:0] CODE_SET_A     = 2'd0;
   localparam logic [1:0] CODE_SET_B     = 2'd1;
   localparam logic [1:0] CODE_SET_C     = 2'd2;
   localparam logic [1:0] CODE_SET_NONE  = 2'd3;
   localparam logic [1:0] CODE_SET_RESET = CODE_SET_B;

   localparam logic ERR_NONE          = 1'b0;
   localparam logic ERR_NOT_ENCODABLE = 1'b1;

   localparam int MODULUS      = 103;
   localparam int REDUCE_STEPS = 8;
   localparam int START_BASE   = 103;

   localparam logic [12:0] STOP_PATTERN = 13'b1100011101011;
   localparam logic [3:0]  SYMBOL_BITS  = 4'd11;
   localparam logic [3:0]  STOP_BITS    = 4'd13;

   localparam logic [3:0] SLOT_START = 4'b0001;
   localparam logic [3:0] SLOT_DATA  = 4'b0010;
   localparam logic [3:0] SLOT_TAIL  = 4'b0100;
   localparam logic [3:0] SLOT_STOP  = 4'b1000;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   typedef struct packed {
      logic       has_start;
      logic       has_data;
      logic       has_err;
      logic       has_end;
      logic [1:0] start_set;
      logic [6:0] data_val;
      logic [6:0] data_term;
   } entry_type;

   function automatic logic [10:0] sym_pattern(input logic [6:0] value);
      logic [10:0] pat;
      case (value)
         7'd0:   pat = 11'b11011001100;
         7'd1:   pat = 11'b11001101100;
         7'd2:   pat = 11'b11001100110;
         7'd3:   pat = 11'b10010011000;
         7'd4:   pat = 11'b10010001100;
         7'd5:   pat = 11'b10001001100;
         7'd6:   pat = 11'b10011001000;
         7'd7:   pat = 11'b10011000100;
         7'd8:   pat = 11'b10001100100;
         7'd9:   pat = 11'b11001001000;
         7'd10:  pat = 11'b11001000100;
         7'd11:  pat = 11'b11000100100;
         7'd12:  pat = 11'b10110011100;
         7'd13:  pat = 11'b10011011100;
         7'd14:  pat = 11'b10011001110;
         7'd15:  pat = 11'b10111001100;
         7'd16:  pat = 11'b10011101100;
         7'd17:  pat = 11'b10011100110;
         7'd18:  pat = 11'b11001110010;
         7'd19:  pat = 11'b11001011100;
         7'd20:  pat = 11'b11001001110;
         7'd21:  pat = 11'b11011100100;
         7'd22:  pat = 11'b11001110100;
         7'd23:  pat = 11'b11101101110;
         7'd24:  pat = 11'b11101001100;
         7'd25:  pat = 11'b11100101100;
         7'd26:  pat = 11'b11100100110;
         7'd27:  pat = 11'b11101100100;
         7'd28:  pat = 11'b11100110100;
         7'd29:  pat = 11'b11100110010;
         7'd30:  pat = 11'b11011011000;
         7'd31:  pat = 11'b11011000110;
         7'd32:  pat = 11'b11000110110;
         7'd33:  pat = 11'b10100011000;
         7'd34:  pat = 11'b10001011000;
         7'd35:  pat = 11'b10001000110;
         7'd36:  pat = 11'b10110001000;
         7'd37:  pat = 11'b10001101000;
         7'd38:  pat = 11'b10001100010;
         7'd39:  pat = 11'b11010001000;
         7'd40:  pat = 11'b11000101000;
         7'd41:  pat = 11'b11000100010;
         7'd42:  pat = 11'b10110111000;
         7'd43:  pat = 11'b10110001110;
         7'd44:  pat = 11'b10001101110;
         7'd45:  pat = 11'b10111011000;
         7'd46:  pat = 11'b10111000110;
         7'd47:  pat = 11'b10001110110;
         7'd48:  pat = 11'b11101110110;
         7'd49:  pat = 11'b11010001110;
         7'd50:  pat = 11'b11000101110;
         7'd51:  pat = 11'b11011101000;
         7'd52:  pat = 11'b11011100010;
         7'd53:  pat = 11'b11011101110;
         7'd54:  pat = 11'b11101011000;
         7'd55:  pat = 11'b11101000110;
         7'd56:  pat = 11'b11100010110;
         7'd57:  pat = 11'b11101101000;
         7'd58:  pat = 11'b11101100010;
         7'd59:  pat = 11'b11100011010;
         7'd60:  pat = 11'b11101111010;
         7'd61:  pat = 11'b11001000010;
         7'd62:  pat = 11'b11110001010;
         7'd63:  pat = 11'b10100110000;
         7'd64:  pat = 11'b10100001100;
         7'd65:  pat = 11'b10010110000;
         7'd66:  pat = 11'b10010000110;
         7'd67:  pat = 11'b10000101100;
         7'd68:  pat = 11'b10000100110;
         7'd69:  pat = 11'b10110010000;
         7'd70:  pat = 11'b10110000100;
         7'd71:  pat = 11'b10011010000;
         7'd72:  pat = 11'b10011000010;
         7'd73:  pat = 11'b10000110100;
         7'd74:  pat = 11'b10000110010;
         7'd75:  pat = 11'b11000010010;
         7'd76:  pat = 11'b11001010000;
         7'd77:  pat = 11'b11110111010;
         7'd78:  pat = 11'b11000010100;
         7'd79:  pat = 11'b10001111010;
         7'd80:  pat = 11'b10100111100;
         7'd81:  pat = 11'b10010111100;
         7'd82:  pat = 11'b10010011110;
         7'd83:  pat = 11'b10111100100;
         7'd84:  pat = 11'b10011110100;
         7'd85:  pat = 11'b10011110010;
         7'd86:  pat = 11'b11110100100;
         7'd87:  pat = 11'b11110010100;
         7'd88:  pat = 11'b11110010010;
         7'd89:  pat = 11'b11011011110;
         7'd90:  pat = 11'b11011110110;
         7'd91:  pat = 11'b11110110110;
         7'd92:  pat = 11'b10101111000;
         7'd93:  pat = 11'b10100011110;
         7'd94:  pat = 11'b10001011110;
         7'd95:  pat = 11'b10111101000;
         7'd96:  pat = 11'b10111100010;
         7'd97:  pat = 11'b11110101000;
         7'd98:  pat = 11'b11110100010;
         7'd99:  pat = 11'b10111011110;
         7'd100: pat = 11'b10111101110;
         7'd101: pat = 11'b11101011110;
         7'd102: pat = 11'b11110101110;
         7'd103: pat = 11'b11010000100;
         7'd104: pat = 11'b11010010000;
         7'd105: pat = 11'b11010011100;
         default: pat = 11'b11011001100;
      endcase
      return pat;
   endfunction

endpackage

### rtl/c128_front.sv
module c128_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [1:0]            csr_wr_data,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,  // char_code
   input  logic [1:0]            req_tuser,  // first_char, odd_length
   input  logic                  req_tlast,  // last_char
   output logic                  push,
   output c128_pkg::entry_type   push_entry,
   input  logic                  full
);

   logic [1:0]  code_set_ff;
   logic        in_msg_ff, in_msg_in;
   logic [6:0]  held_tens_ff, held_tens_in;
   logic        held_valid_ff, held_valid_in;
   logic [6:0]  weight_ff, weight_in;

   logic                 s1_valid_ff, s1_valid_in;
   c128_pkg::entry_type  s1_entry_ff, s1_entry_in;
   logic [13:0]          s1_prod_ff, s1_prod_in;

   logic        accept;
   logic        first_c, last_c, odd_c;
   logic        active, ok, emit, any_result;
   logic [6:0]  v, w, w_inc;
   logic [7:0]  c_minus_32;
   logic [3:0]  digit;
   logic [6:0]  tens;
   logic        hv;
   logic [13:0] red;

   assign first_c    = req_tuser[0];
   assign odd_c      = req_tuser[1];
   assign last_c     = req_tlast;
   assign req_tready = !s1_valid_ff || !full;
   assign accept     = req_tvalid && req_tready;
   assign push       = s1_valid_ff && !full;
   assign c_minus_32 = req_tdata - 8'd32;
   assign digit      = 4'(req_tdata - 8'd48);

   always_comb begin
      active        = first_c || in_msg_ff;
      tens          = first_c ? 7'd0 : held_tens_ff;
      hv            = first_c ? 1'b0 : held_valid_ff;
      w             = first_c ? 7'd0 : weight_ff;
      ok            = 1'b1;
      emit          = 1'b1;
      v             = 7'd0;
      s1_entry_in   = '0;
      s1_entry_in.start_set = code_set_ff;
      s1_entry_in.has_start = first_c && (code_set_ff != c128_pkg::CODE_SET_NONE);
      if (s1_entry_in.has_start) begin
         w = 7'd1;
         if (code_set_ff == c128_pkg::CODE_SET_C && odd_c) begin
            tens = 7'd0;
            hv   = 1'b1;
         end
      end
      case (code_set_ff)
         c128_pkg::CODE_SET_A: begin
            if (req_tdata < 8'd32) v = req_tdata[6:0] + 7'd64;
            else if (req_tdata < 8'd96) v = c_minus_32[6:0];
            else ok = 1'b0;
         end
         c128_pkg::CODE_SET_B: begin
            if (req_tdata >= 8'd32 && req_tdata < 8'd128) v = c_minus_32[6:0];
            else ok = 1'b0;
         end
         c128_pkg::CODE_SET_C: begin
            if (req_tdata >= 8'd48 && req_tdata <= 8'd57) begin
               if (hv) begin
                  v    = tens + {3'd0, digit};
                  hv   = 1'b0;
                  tens = 7'd0;
               end else begin
                  tens = ({3'd0, digit} << 3) + ({3'd0, digit} << 1);
                  hv   = 1'b1;
                  emit = 1'b0;
               end
            end else begin
               ok = 1'b0;
            end
         end
         default: ok = 1'b0;
      endcase
      s1_entry_in.has_data = active && ok && emit;
      if (ok && last_c && hv) ok = 1'b0;
      s1_entry_in.has_err  = active && !ok;
      s1_entry_in.has_end  = active && ok && last_c;
      s1_entry_in.data_val = v;
      any_result = s1_entry_in.has_start || s1_entry_in.has_data
                   || s1_entry_in.has_err || s1_entry_in.has_end;
      s1_prod_in = 14'(v) * 14'(w);
      w_inc      = (w == 7'(c128_pkg::MODULUS - 1)) ? 7'd0 : w + 7'd1;
   end

   always_comb begin
      in_msg_in     = in_msg_ff;
      held_tens_in  = held_tens_ff;
      held_valid_in = held_valid_ff;
      weight_in     = weight_ff;
      if (accept && active) begin
         if (s1_entry_in.has_err || s1_entry_in.has_end) begin
            in_msg_in     = 1'b0;
            held_tens_in  = 7'd0;
            held_valid_in = 1'b0;
            weight_in     = 7'd0;
         end else begin
            in_msg_in     = 1'b1;
            held_tens_in  = tens;
            held_valid_in = hv;
            weight_in     = s1_entry_in.has_data ? w_inc : w;
         end
      end
      if (accept) s1_valid_in = any_result;
      else if (push) s1_valid_in = 1'b0;
      else s1_valid_in = s1_valid_ff;
   end

   // reduce the weighted term mod 103 by restoring subtraction
   always_comb begin
      red = s1_prod_ff;
      for (int k = c128_pkg::REDUCE_STEPS - 1; k >= 0; k--) begin
         if (red >= (14'(c128_pkg::MODULUS) << k)) red = red - (14'(c128_pkg::MODULUS) << k);
      end
      push_entry           = s1_entry_ff;
      push_entry.data_term = red[6:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_set_ff   <= c128_pkg::CODE_SET_RESET;
         in_msg_ff     <= 1'b0;
         held_tens_ff  <= 7'd0;
         held_valid_ff <= 1'b0;
         weight_ff     <= 7'd0;
         s1_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) code_set_ff <= csr_wr_data;
         in_msg_ff     <= in_msg_in;
         held_tens_ff  <= held_tens_in;
         held_valid_ff <= held_valid_in;
         weight_ff     <= weight_in;
         s1_valid_ff   <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_entry_ff <= s1_entry_in;
         s1_prod_ff  <= s1_prod_in;
      end
   end

endmodule

### rtl/c128_fifo.sv
module c128_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  c128_pkg::entry_type   push_entry,
   output logic                  full,
   input  logic                  pop,
   output c128_pkg::entry_type   head,
   output logic                  empty
);

   c128_pkg::entry_type                mem_ff [c128_pkg::QUEUE_DEPTH];
   logic [c128_pkg::QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [c128_pkg::QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [c128_pkg::QUEUE_AW:0]        count_ff, count_in;

   assign full  = (count_ff == (c128_pkg::QUEUE_AW + 1)'(c128_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      else if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

### rtl/c128_back.sv
module c128_back (
   input  logic                  clock,
   input  logic                  reset,
   input  c128_pkg::entry_type   head,
   input  logic                  empty,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,  // bar_pattern[12:0], pattern_bits[16:13], zeros
   output logic [0:0]            rsp_tuser,  // error_code
   output logic                  rsp_tlast   // last_pattern
);

   logic [3:0]  done_ff, done_in;
   logic [6:0]  acc_ff, acc_in;
   logic        valid_ff, valid_in;
   logic [12:0] pat_ff, pat_in;
   logic [3:0]  bits_ff, bits_in;
   logic        last_ff, last_in;
   logic        err_ff, err_in;

   logic [3:0]  pending, sel;
   logic        load;
   logic [6:0]  sym_val;
   logic [7:0]  acc_sum;

   assign pending = {head.has_end, head.has_err || head.has_end, head.has_data, head.has_start}
                    & ~done_ff;
   assign sel     = pending & 4'(~pending + 4'd1);
   assign load    = !empty && (!valid_ff || rsp_tready);
   assign pop     = load && ((pending & ~sel) == 4'd0);
   assign acc_sum = {1'b0, acc_ff} + {1'b0, head.data_term};

   always_comb begin
      case (sel)
         c128_pkg::SLOT_START: sym_val = 7'(c128_pkg::START_BASE) + {5'd0, head.start_set};
         c128_pkg::SLOT_DATA:  sym_val = head.data_val;
         default:              sym_val = acc_ff;
      endcase
   end

   always_comb begin
      pat_in   = pat_ff;
      bits_in  = bits_ff;
      last_in  = last_ff;
      err_in   = err_ff;
      acc_in   = acc_ff;
      done_in  = done_ff;
      valid_in = valid_ff && !rsp_tready;
      if (load) begin
         valid_in = 1'b1;
         done_in  = pop ? 4'd0 : (done_ff | sel);
         pat_in   = {2'd0, c128_pkg::sym_pattern(sym_val)};
         bits_in  = c128_pkg::SYMBOL_BITS;
         last_in  = 1'b0;
         err_in   = c128_pkg::ERR_NONE;
         case (sel)
            c128_pkg::SLOT_START: acc_in = {5'd0, head.start_set};
            c128_pkg::SLOT_DATA: begin
               acc_in = (acc_sum >= 8'(c128_pkg::MODULUS))
                        ? 7'(acc_sum - 8'(c128_pkg::MODULUS)) : acc_sum[6:0];
            end
            c128_pkg::SLOT_TAIL: begin
               if (head.has_err) begin
                  pat_in  = 13'd0;
                  bits_in = 4'd0;
                  last_in = 1'b1;
                  err_in  = c128_pkg::ERR_NOT_ENCODABLE;
               end
            end
            c128_pkg::SLOT_STOP: begin
               pat_in  = c128_pkg::STOP_PATTERN;
               bits_in = c128_pkg::STOP_BITS;
               last_in = 1'b1;
            end
            default: acc_in = acc_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff  <= 4'd0;
         acc_ff   <= 7'd0;
         valid_ff <= 1'b0;
      end else begin
         done_ff  <= done_in;
         acc_ff   <= acc_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pat_ff  <= pat_in;
      bits_ff <= bits_in;
      last_ff <= last_in;
      err_ff  <= err_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {7'd0, bits_ff, pat_ff};
   assign rsp_tuser  = err_ff;
   assign rsp_tlast  = last_ff;

endmodule

### rtl/code128_symbol_encoder_top.sv
// channel   ports      tdata                         tuser                    tlast
// request   req_*      char_code[7:0]                first_char, odd_length   last_char
// response  rsp_*      bar_pattern, pattern_bits     error_code               last_pattern
// csr       csr_wr_*   code_set[1:0], write only     -                        -
//
// One word leaves the response register per cycle while rsp_tready is high; a character yields
// at most one word mid-message, two on a first character (start, data), three on a last (data,
// check, stop), four on one that is both. Words pass the front stage and the queue first.
// Reset is synchronous; it clears the message state and selects set B.
// A stalled response fills the response register, a four-character queue and the front
// stage before req_tready drops.
module code128_symbol_encoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data,  // code_set
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // char_code
   input  logic [1:0]  req_tuser,    // first_char, odd_length
   input  logic        req_tlast,    // last_char
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // bar_pattern[12:0], pattern_bits[16:13], zeros
   output logic [0:0]  rsp_tuser,    // error_code
   output logic        rsp_tlast     // last_pattern
);

   logic                 push, full, pop, empty;
   c128_pkg::entry_type  push_entry, head;

   c128_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .req_tlast   (req_tlast),
      .push        (push),
      .push_entry  (push_entry),
      .full        (full)
   );

   c128_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head       (head),
      .empty      (empty)
   );

   c128_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .empty      (empty),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   a_err_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast && rsp_tdata[16:0] == 17'd0)
      else $error("error word not final or not blank");

   a_ok_bits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |->
      (rsp_tdata[16:13] == c128_pkg::SYMBOL_BITS || rsp_tdata[16:13] == c128_pkg::STOP_BITS))
      else $error("bad module count");

   a_stop_word: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16:13] == c128_pkg::STOP_BITS |->
      rsp_tlast && rsp_tdata[12:0] == c128_pkg::STOP_PATTERN)
      else $error("stop word malformed");

   a_queue_hold: assert property (@(posedge clock) disable iff (reset)
      full && !pop |=> full)
      else $error("queue lost a word");
`endif

endmodule
